// ===== sv/gftp_pkg.sv =====
`timescale 1ns / 1ps
package gftp_pkg;

  localparam int unsigned NUM_ITER = 16;
  localparam logic [7:0] CENTRE = 8'd50;
  localparam logic signed [16:0] ROT_GAIN = 17'sd39797;
  localparam logic signed [26:0] Z_90 = 27'sd5898240;

  typedef enum logic [2:0] {
    CFG_START_MARKER = 3'd0,
    CFG_END_MARKER = 3'd1,
    CFG_UNKNOWN_MARKER = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_ATTACK_IS_YELLOW = 3'd5,
    CFG_WEIGHT_X = 3'd6,
    CFG_WEIGHT_Y = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_FMX, S_FAX, S_FMY, S_FAY, S_VINIT, S_VITER, S_ANG,
    S_SQX, S_SQY, S_SQS, S_SQRT, S_RINIT, S_RITER, S_GMX, S_GMY, S_GAY,
    S_AFIX, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_IDLE, OP_LOAD, OP_FMUL_X, OP_FADD_X, OP_FMUL_Y, OP_FADD_Y,
    OP_VINIT, OP_CITER, OP_ANG, OP_SQX, OP_SQY, OP_SQS, OP_SQRT, OP_RINIT,
    OP_GMX, OP_GMY, OP_GAY, OP_AFIX, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
    logic goal;
    logic phase;
    logic [3:0] iter;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_busy;
  } status_t;

  function automatic logic [22:0] atan_tab(input logic [3:0] i);
    logic [22:0] v;
    case (i)
      4'd0: v = 23'd2949120;
      4'd1: v = 23'd1740967;
      4'd2: v = 23'd919879;
      4'd3: v = 23'd466945;
      4'd4: v = 23'd234379;
      4'd5: v = 23'd117304;
      4'd6: v = 23'd58666;
      4'd7: v = 23'd29335;
      4'd8: v = 23'd14668;
      4'd9: v = 23'd7334;
      4'd10: v = 23'd3667;
      4'd11: v = 23'd1833;
      4'd12: v = 23'd917;
      4'd13: v = 23'd458;
      4'd14: v = 23'd229;
      4'd15: v = 23'd115;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [44:0] v);
    logic signed [15:0] r;
    if (v > 45'sd32767) r = 16'sh7fff;
    else if (v < -45'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [10:0] trunc16(input logic signed [26:0] a);
    logic signed [26:0] m;
    logic signed [10:0] r;
    if (a < 0) begin
      m = -a;
      r = -11'(m >>> 16);
    end else begin
      r = 11'(a >>> 16);
    end
    return r;
  endfunction

endpackage

// ===== sv/gftp_in_if.sv =====
`timescale 1ns / 1ps
interface gftp_in_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  logic [8:0] imu_heading;
  modport source (output valid, output rx_byte, output imu_heading, input ready);
  modport sink (input valid, input rx_byte, input imu_heading, output ready);
endinterface

// ===== sv/gftp_out_if.sv =====
`timescale 1ns / 1ps
interface gftp_out_if;
  logic valid;
  logic ready;
  logic [8:0] atk_angle;
  logic signed [9:0] atk_angle_fixed;
  logic [15:0] atk_dist;
  logic atk_seen;
  logic signed [15:0] atk_x_fixed;
  logic signed [15:0] atk_y_fixed;
  logic [8:0] def_angle;
  logic signed [9:0] def_angle_fixed;
  logic [15:0] def_dist;
  logic def_seen;
  logic signed [15:0] def_x_fixed;
  logic signed [15:0] def_y_fixed;
  modport source (output valid, input ready, output atk_angle, output atk_angle_fixed,
    output atk_dist, output atk_seen, output atk_x_fixed, output atk_y_fixed,
    output def_angle, output def_angle_fixed, output def_dist, output def_seen,
    output def_x_fixed, output def_y_fixed);
  modport sink (input valid, output ready, input atk_angle, input atk_angle_fixed,
    input atk_dist, input atk_seen, input atk_x_fixed, input atk_y_fixed,
    input def_angle, input def_angle_fixed, input def_dist, input def_seen,
    input def_x_fixed, input def_y_fixed);
endinterface

// ===== sv/gftp_cfg_if.sv =====
`timescale 1ns / 1ps
interface gftp_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/goal_frame_to_polar_tracker_top.sv =====
`timescale 1ns / 1ps
// A byte that opens, fills or stray-ends a frame gives no result. A closing end byte
// starts the work for both goals, each with filters, two 16-step CORDIC vectoring
// passes, a 16-step CORDIC rotation and a 16-step root, and then emits the result.
// Throughput: one byte per cycle between frames;
// input held off while computing and while an earlier result waits for its transfer.
// Reset: synchronous active-low rst_n; registers to defaults, filter memory and frame
// state cleared, no result pending.
module goal_frame_to_polar_tracker_top (
  input logic clk,
  input logic rst_n,
  gftp_in_if.sink in_ch,
  gftp_out_if.source out_ch,
  gftp_cfg_if.sink cfg_ch
);

  gftp_pkg::cmd_t cmd;
  gftp_pkg::status_t st;

  gftp_ctrl u_ctrl (
    .clk (clk),
    .rst_n (rst_n),
    .st (st),
    .cmd (cmd)
  );

  gftp_dp u_dp (
    .clk (clk),
    .rst_n (rst_n),
    .cmd (cmd),
    .st (st),
    .in_ch (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == gftp_pkg::OP_EMIT) |-> !st.out_busy)
    else $error("result loaded over a pending transfer");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (cmd.op == gftp_pkg::OP_IDLE))
    else $error("input taken during computation");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.op == gftp_pkg::OP_EMIT))
    else $error("result valid without emit");
`endif

endmodule

// ===== sv/gftp_ctrl.sv =====
`timescale 1ns / 1ps
module gftp_ctrl (
  input logic clk,
  input logic rst_n,
  input gftp_pkg::status_t st,
  output gftp_pkg::cmd_t cmd
);

  gftp_pkg::state_t state_r, state_nxt;
  logic goal_r, goal_nxt;
  logic phase_r, phase_nxt;
  logic [3:0] iter_r, iter_nxt;
  logic last_iter;

  assign last_iter = (iter_r == 4'(gftp_pkg::NUM_ITER - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gftp_pkg::S_IDLE;
      goal_r <= 1'b0;
      phase_r <= 1'b0;
      iter_r <= '0;
    end else begin
      state_r <= state_nxt;
      goal_r <= goal_nxt;
      phase_r <= phase_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    goal_nxt = goal_r;
    phase_nxt = phase_r;
    iter_nxt = '0;
    case (state_r)
      gftp_pkg::S_IDLE: begin
        if (st.frame_done) begin
          state_nxt = gftp_pkg::S_LOAD;
          goal_nxt = 1'b0;
          phase_nxt = 1'b0;
        end
      end
      gftp_pkg::S_LOAD: state_nxt = gftp_pkg::S_FMX;
      gftp_pkg::S_FMX: state_nxt = gftp_pkg::S_FAX;
      gftp_pkg::S_FAX: state_nxt = gftp_pkg::S_FMY;
      gftp_pkg::S_FMY: state_nxt = gftp_pkg::S_FAY;
      gftp_pkg::S_FAY: state_nxt = gftp_pkg::S_VINIT;
      gftp_pkg::S_VINIT: state_nxt = gftp_pkg::S_VITER;
      gftp_pkg::S_VITER: begin
        iter_nxt = iter_r + 4'd1;
        if (last_iter) state_nxt = phase_r ? gftp_pkg::S_AFIX : gftp_pkg::S_ANG;
      end
      gftp_pkg::S_ANG: state_nxt = gftp_pkg::S_SQX;
      gftp_pkg::S_SQX: state_nxt = gftp_pkg::S_SQY;
      gftp_pkg::S_SQY: state_nxt = gftp_pkg::S_SQS;
      gftp_pkg::S_SQS: state_nxt = gftp_pkg::S_SQRT;
      gftp_pkg::S_SQRT: begin
        iter_nxt = iter_r + 4'd1;
        if (last_iter) state_nxt = gftp_pkg::S_RINIT;
      end
      gftp_pkg::S_RINIT: state_nxt = gftp_pkg::S_RITER;
      gftp_pkg::S_RITER: begin
        iter_nxt = iter_r + 4'd1;
        if (last_iter) state_nxt = gftp_pkg::S_GMX;
      end
      gftp_pkg::S_GMX: state_nxt = gftp_pkg::S_GMY;
      gftp_pkg::S_GMY: state_nxt = gftp_pkg::S_GAY;
      gftp_pkg::S_GAY: begin
        state_nxt = gftp_pkg::S_FMX;
        phase_nxt = 1'b1;
      end
      gftp_pkg::S_AFIX: begin
        if (!goal_r) begin
          state_nxt = gftp_pkg::S_LOAD;
          goal_nxt = 1'b1;
          phase_nxt = 1'b0;
        end else begin
          state_nxt = gftp_pkg::S_EMIT;
        end
      end
      gftp_pkg::S_EMIT: if (!st.out_busy) state_nxt = gftp_pkg::S_IDLE;
      default: state_nxt = gftp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.goal = goal_r;
    cmd.phase = phase_r;
    cmd.iter = iter_r;
    case (state_r)
      gftp_pkg::S_IDLE: cmd.op = gftp_pkg::OP_IDLE;
      gftp_pkg::S_LOAD: cmd.op = gftp_pkg::OP_LOAD;
      gftp_pkg::S_FMX: cmd.op = gftp_pkg::OP_FMUL_X;
      gftp_pkg::S_FAX: cmd.op = gftp_pkg::OP_FADD_X;
      gftp_pkg::S_FMY: cmd.op = gftp_pkg::OP_FMUL_Y;
      gftp_pkg::S_FAY: cmd.op = gftp_pkg::OP_FADD_Y;
      gftp_pkg::S_VINIT: cmd.op = gftp_pkg::OP_VINIT;
      gftp_pkg::S_VITER: cmd.op = gftp_pkg::OP_CITER;
      gftp_pkg::S_ANG: cmd.op = gftp_pkg::OP_ANG;
      gftp_pkg::S_SQX: cmd.op = gftp_pkg::OP_SQX;
      gftp_pkg::S_SQY: cmd.op = gftp_pkg::OP_SQY;
      gftp_pkg::S_SQS: cmd.op = gftp_pkg::OP_SQS;
      gftp_pkg::S_SQRT: cmd.op = gftp_pkg::OP_SQRT;
      gftp_pkg::S_RINIT: cmd.op = gftp_pkg::OP_RINIT;
      gftp_pkg::S_RITER: cmd.op = gftp_pkg::OP_CITER;
      gftp_pkg::S_GMX: cmd.op = gftp_pkg::OP_GMX;
      gftp_pkg::S_GMY: cmd.op = gftp_pkg::OP_GMY;
      gftp_pkg::S_GAY: cmd.op = gftp_pkg::OP_GAY;
      gftp_pkg::S_AFIX: cmd.op = gftp_pkg::OP_AFIX;
      gftp_pkg::S_EMIT: cmd.op = st.out_busy ? gftp_pkg::OP_NOP : gftp_pkg::OP_EMIT;
      default: cmd.op = gftp_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== sv/gftp_dp.sv =====
`timescale 1ns / 1ps
module gftp_dp (
  input logic clk,
  input logic rst_n,
  input gftp_pkg::cmd_t cmd,
  output gftp_pkg::status_t st,
  gftp_in_if.sink in_ch,
  gftp_out_if.source out_ch,
  gftp_cfg_if.sink cfg_ch
);

  logic [7:0] start_r, end_r, unk_r;
  logic signed [14:0] offx_r, offy_r;
  logic yel_atk_r;
  logic [15:0] wx_r, wy_r;

  logic in_frame_r;
  logic [2:0] idx_r;
  logic [7:0] raw0_r, raw1_r, raw2_r, raw3_r;
  logic [8:0] imu_r;
  logic signed [15:0] fmem_r [8];

  logic signed [15:0] xa_r, ya_r;
  logic signed [43:0] prod_r;
  logic [31:0] sacc_r, sv_r;
  logic [17:0] srem_r;
  logic [15:0] sroot_r;
  logic signed [26:0] cx_r, cy_r;
  logic signed [25:0] cz_r;
  logic rot_r, zero_r;

  logic [8:0] ra_ang_r, rd_ang_r;
  logic signed [9:0] ra_angf_r, rd_angf_r;
  logic [15:0] ra_dist_r, rd_dist_r;
  logic ra_seen_r, rd_seen_r;
  logic signed [15:0] ra_x_r, ra_y_r, rd_x_r, rd_y_r;
  logic out_valid_r;

  logic accept, is_start, is_end;
  logic [7:0] rawx, rawy;
  logic sel_atk;
  logic [2:0] fidx;
  logic axis_y;
  logic signed [15:0] fin;
  logic signed [18:0] rcx, rcy;
  logic signed [26:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] mul_p;
  logic signed [44:0] facc;
  logic signed [15:0] fres;
  logic signed [44:0] gacc;
  logic signed [15:0] gres;
  logic signed [26:0] sx, sy;
  logic signed [9:0] deg;
  logic ccw;
  logic signed [26:0] xsh, ysh;
  logic signed [25:0] tab;
  logic signed [26:0] zz;
  logic signed [10:0] tang, tangf;
  logic [19:0] remt, trial;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (cmd.op == gftp_pkg::OP_IDLE);
  assign is_start = (in_ch.rx_byte == start_r);
  assign is_end = (in_ch.rx_byte == end_r);
  assign st.frame_done = in_ch.valid && !is_start && is_end && in_frame_r && (idx_r == 3'd4);
  assign st.out_busy = out_valid_r && !out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign rawx = cmd.goal ? raw2_r : raw0_r;
  assign rawy = cmd.goal ? raw3_r : raw1_r;
  assign sel_atk = (cmd.goal == yel_atk_r);
  assign axis_y = (cmd.op == gftp_pkg::OP_FMUL_Y) || (cmd.op == gftp_pkg::OP_FADD_Y);
  assign fidx = {cmd.phase, cmd.goal, axis_y};
  assign fin = axis_y ? ya_r : xa_r;

  assign rcx = (($signed({11'd0, gftp_pkg::CENTRE}) - $signed({11'd0, rawx})) <<< 8)
               + 19'(offx_r);
  assign rcy = (($signed({11'd0, rawy}) - $signed({11'd0, gftp_pkg::CENTRE})) <<< 8)
               + 19'(offy_r);

  always_comb begin
    case (cmd.op)
      gftp_pkg::OP_FMUL_X, gftp_pkg::OP_FMUL_Y: begin
        mul_a = 27'(17'(fmem_r[fidx]) - 17'(fin));
        mul_b = $signed({1'b0, axis_y ? wy_r : wx_r});
      end
      gftp_pkg::OP_SQX: begin
        mul_a = 27'(xa_r);
        mul_b = 17'(xa_r);
      end
      gftp_pkg::OP_SQY: begin
        mul_a = 27'(ya_r);
        mul_b = 17'(ya_r);
      end
      gftp_pkg::OP_GMY: begin
        mul_a = cy_r;
        mul_b = gftp_pkg::ROT_GAIN;
      end
      default: begin
        mul_a = cx_r;
        mul_b = gftp_pkg::ROT_GAIN;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign facc = (45'(fin) <<< 16) + 45'(prod_r) + 45'sd32768;
  assign fres = gftp_pkg::sat16(facc >>> 16);
  assign gacc = (45'(prod_r) + 45'sd8388608) >>> 24;
  assign gres = gftp_pkg::sat16(gacc);

  assign sx = 27'(xa_r) <<< 8;
  assign sy = 27'(ya_r) <<< 8;
  assign deg = (imu_r > 9'd180) ? 10'(10'sd360 - $signed({1'b0, imu_r}))
                                : 10'(-$signed({1'b0, imu_r}));

  assign ccw = rot_r ? !cz_r[25] : !(cy_r > 0);
  assign xsh = cx_r >>> cmd.iter;
  assign ysh = cy_r >>> cmd.iter;
  assign tab = $signed({3'd0, gftp_pkg::atan_tab(cmd.iter)});

  assign zz = zero_r ? 27'sd0 : 27'(cz_r);
  assign tang = gftp_pkg::trunc16(zz - gftp_pkg::Z_90);
  assign tangf = gftp_pkg::trunc16(gftp_pkg::Z_90 - zz);

  assign remt = {srem_r, sv_r[31:30]};
  assign trial = {2'd0, sroot_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 8'd0;
      end_r <= 8'd255;
      unk_r <= 8'd128;
      offx_r <= '0;
      offy_r <= '0;
      yel_atk_r <= 1'b0;
      wx_r <= '0;
      wy_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        gftp_pkg::CFG_START_MARKER: start_r <= cfg_ch.data[7:0];
        gftp_pkg::CFG_END_MARKER: end_r <= cfg_ch.data[7:0];
        gftp_pkg::CFG_UNKNOWN_MARKER: unk_r <= cfg_ch.data[7:0];
        gftp_pkg::CFG_OFFSET_X: offx_r <= cfg_ch.data[14:0];
        gftp_pkg::CFG_OFFSET_Y: offy_r <= cfg_ch.data[14:0];
        gftp_pkg::CFG_ATTACK_IS_YELLOW: yel_atk_r <= cfg_ch.data[0];
        gftp_pkg::CFG_WEIGHT_X: wx_r <= cfg_ch.data;
        gftp_pkg::CFG_WEIGHT_Y: wy_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      idx_r <= '0;
      raw0_r <= '0;
      raw1_r <= '0;
      raw2_r <= '0;
      raw3_r <= '0;
    end else if (accept) begin
      if (is_start) begin
        in_frame_r <= 1'b1;
        idx_r <= '0;
      end else if (!is_end) begin
        if (in_frame_r) begin
          case (idx_r)
            3'd0: raw0_r <= in_ch.rx_byte;
            3'd1: raw1_r <= in_ch.rx_byte;
            3'd2: raw2_r <= in_ch.rx_byte;
            3'd3: raw3_r <= in_ch.rx_byte;
            default: ;
          endcase
          if (idx_r != 3'd7) idx_r <= idx_r + 3'd1;
        end
      end else begin
        in_frame_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) fmem_r[i] <= '0;
    end else if (cmd.op == gftp_pkg::OP_FADD_X || cmd.op == gftp_pkg::OP_FADD_Y) begin
      fmem_r[fidx] <= fres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == gftp_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) imu_r <= in_ch.imu_heading;
    case (cmd.op)
      gftp_pkg::OP_LOAD: begin
        xa_r <= gftp_pkg::sat16(45'(rcx));
        ya_r <= gftp_pkg::sat16(45'(rcy));
        if (sel_atk) ra_seen_r <= (rawx != unk_r) && (rawy != unk_r);
        else rd_seen_r <= (rawx != unk_r) && (rawy != unk_r);
      end
      gftp_pkg::OP_FMUL_X, gftp_pkg::OP_FMUL_Y, gftp_pkg::OP_SQX, gftp_pkg::OP_GMX: begin
        prod_r <= mul_p;
      end
      gftp_pkg::OP_FADD_X: xa_r <= fres;
      gftp_pkg::OP_FADD_Y: ya_r <= fres;
      gftp_pkg::OP_VINIT: begin
        rot_r <= 1'b0;
        zero_r <= (xa_r == 16'sd0) && (ya_r == 16'sd0);
        if (xa_r < 0) begin
          if (ya_r >= 0) begin
            cx_r <= sy;
            cy_r <= -sx;
            cz_r <= 26'(gftp_pkg::Z_90);
          end else begin
            cx_r <= -sy;
            cy_r <= sx;
            cz_r <= 26'(-gftp_pkg::Z_90);
          end
        end else begin
          cx_r <= sx;
          cy_r <= sy;
          cz_r <= '0;
        end
      end
      gftp_pkg::OP_RINIT: begin
        rot_r <= 1'b1;
        if (sel_atk) ra_dist_r <= sroot_r;
        else rd_dist_r <= sroot_r;
        if (deg > 10'sd90) begin
          cx_r <= -sy;
          cy_r <= sx;
          cz_r <= 26'(deg - 10'sd90) <<< 16;
        end else if (deg < -10'sd90) begin
          cx_r <= sy;
          cy_r <= -sx;
          cz_r <= 26'(deg + 10'sd90) <<< 16;
        end else begin
          cx_r <= sx;
          cy_r <= sy;
          cz_r <= 26'(deg) <<< 16;
        end
      end
      gftp_pkg::OP_CITER: begin
        if (ccw) begin
          cx_r <= cx_r - ysh;
          cy_r <= cy_r + xsh;
          cz_r <= cz_r - tab;
        end else begin
          cx_r <= cx_r + ysh;
          cy_r <= cy_r - xsh;
          cz_r <= cz_r + tab;
        end
      end
      gftp_pkg::OP_ANG: begin
        if (sel_atk) ra_ang_r <= (tang < 0) ? 9'(tang + 11'sd360) : 9'(tang);
        else rd_ang_r <= (tang < 0) ? 9'(tang + 11'sd360) : 9'(tang);
      end
      gftp_pkg::OP_SQY: begin
        prod_r <= mul_p;
        sacc_r <= prod_r[31:0];
      end
      gftp_pkg::OP_SQS: begin
        sv_r <= sacc_r + prod_r[31:0];
        srem_r <= '0;
        sroot_r <= '0;
      end
      gftp_pkg::OP_SQRT: begin
        sv_r <= {sv_r[29:0], 2'b00};
        if (remt >= trial) begin
          srem_r <= 18'(remt - trial);
          sroot_r <= {sroot_r[14:0], 1'b1};
        end else begin
          srem_r <= 18'(remt);
          sroot_r <= {sroot_r[14:0], 1'b0};
        end
      end
      gftp_pkg::OP_GMY: begin
        prod_r <= mul_p;
        xa_r <= gres;
      end
      gftp_pkg::OP_GAY: ya_r <= gres;
      gftp_pkg::OP_AFIX: begin
        if (sel_atk) begin
          ra_angf_r <= (tangf < -11'sd90) ? -10'sd90 :
                       (tangf > 11'sd270) ? 10'sd270 : 10'(tangf);
          ra_x_r <= xa_r;
          ra_y_r <= ya_r;
        end else begin
          rd_angf_r <= (tangf < -11'sd90) ? -10'sd90 :
                       (tangf > 11'sd270) ? 10'sd270 : 10'(tangf);
          rd_x_r <= xa_r;
          rd_y_r <= ya_r;
        end
      end
      gftp_pkg::OP_EMIT: begin
        out_ch.atk_angle <= ra_ang_r;
        out_ch.atk_angle_fixed <= ra_angf_r;
        out_ch.atk_dist <= ra_dist_r;
        out_ch.atk_seen <= ra_seen_r;
        out_ch.atk_x_fixed <= ra_x_r;
        out_ch.atk_y_fixed <= ra_y_r;
        out_ch.def_angle <= rd_ang_r;
        out_ch.def_angle_fixed <= rd_angf_r;
        out_ch.def_dist <= rd_dist_r;
        out_ch.def_seen <= rd_seen_r;
        out_ch.def_x_fixed <= rd_x_r;
        out_ch.def_y_fixed <= rd_y_r;
      end
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid_r;

endmodule

// ===== tb/goal_frame_to_polar_tracker_checker.sv =====
`timescale 1ns / 1ps
module goal_frame_to_polar_tracker_checker (
  input logic clk,
  input logic rst_n,
  gftp_in_if in_mon,
  gftp_out_if out_mon,
  gftp_cfg_if cfg_mon,
  output int fail_count,
  output int pending,
  output int result_count
);

  typedef struct packed {
    logic [8:0] angle;
    logic signed [9:0] angle_fixed;
    logic [15:0] span;
    logic seen;
    logic signed [15:0] x_fixed;
    logic signed [15:0] y_fixed;
  } goal_t;

  typedef struct packed {
    goal_t atk;
    goal_t def;
  } polar_t;

  localparam longint ARC_DEG [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic [7:0] start_mark, end_mark, unknown_mark;
  logic signed [14:0] off_x, off_y;
  logic yellow_attacks;
  logic [15:0] w_x, w_y;

  logic framing;
  int unsigned coord_count;
  logic [7:0] coords [4];
  longint smooth [8];

  polar_t expected_polar [$];

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint smooth_step(input int idx, input longint v, input longint w);
    longint acc;
    longint y;
    acc = w * smooth[idx] + (65536 - w) * v;
    y = clip16((acc + 32768) >>> 16);
    smooth[idx] = y;
    return y;
  endfunction

  function automatic longint heading_q16(input longint y, input longint x);
    longint z;
    longint t;
    longint nx;
    longint ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_DEG[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_DEG[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic void turn_point(inout longint px, inout longint py, input int deg);
    longint x;
    longint y;
    longint z;
    longint t;
    longint nx;
    longint ny;
    x = px * 256;
    y = py * 256;
    if (deg > 90) begin
      t = x; x = -y; y = t; deg -= 90;
    end else if (deg < -90) begin
      t = x; x = y; y = -t; deg += 90;
    end
    z = longint'(deg) * 65536;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_DEG[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_DEG[i];
      end
      x = nx;
      y = ny;
    end
    px = clip16((x * 39797 + (longint'(1) << 23)) >>> 24);
    py = clip16((y * 39797 + (longint'(1) << 23)) >>> 24);
  endfunction

  function automatic int to_degrees(input longint a);
    if (a >= 0) return int'(a >> 16);
    return -int'((-a) >> 16);
  endfunction

  function automatic longint root_floor(input longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic goal_t track_goal(input int g, input int tilt);
    goal_t res;
    longint x;
    longint y;
    longint xr;
    longint yr;
    int ang;
    int angf;
    x = clip16((50 - longint'(coords[2*g])) * 256 + longint'(off_x));
    y = clip16((longint'(coords[2*g+1]) - 50) * 256 + longint'(off_y));
    x = smooth_step(2*g, x, longint'(w_x));
    y = smooth_step(2*g+1, y, longint'(w_y));
    ang = to_degrees(heading_q16(y, x) - 90 * 65536);
    ang = ((ang % 360) + 360) % 360;
    xr = x;
    yr = y;
    turn_point(xr, yr, -tilt);
    xr = smooth_step(4 + 2*g, xr, longint'(w_x));
    yr = smooth_step(5 + 2*g, yr, longint'(w_y));
    angf = to_degrees(90 * 65536 - heading_q16(yr, xr));
    if (angf < -90) angf = -90;
    if (angf > 270) angf = 270;
    res.angle = ang[8:0];
    res.angle_fixed = angf[9:0];
    res.span = 16'(root_floor(x * x + y * y));
    res.seen = coords[2*g] != unknown_mark && coords[2*g+1] != unknown_mark;
    res.x_fixed = xr[15:0];
    res.y_fixed = yr[15:0];
    return res;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic [8:0] imu);
    int tilt;
    goal_t blue;
    goal_t yellow;
    polar_t p;
    if (b == start_mark) begin
      framing = 1'b1;
      coord_count = 0;
    end else if (b != end_mark) begin
      if (framing) begin
        if (coord_count < 4) coords[coord_count[1:0]] = b;
        if (coord_count < 7) coord_count++;
      end
    end else if (!framing || coord_count != 4) begin
      framing = 1'b0;
    end else begin
      framing = 1'b0;
      tilt = (imu > 180) ? int'(imu) - 360 : int'(imu);
      blue = track_goal(0, tilt);
      yellow = track_goal(1, tilt);
      p.atk = yellow_attacks ? yellow : blue;
      p.def = yellow_attacks ? blue : yellow;
      expected_polar.push_back(p);
    end
  endtask

  function automatic void check_goal(input string side, input goal_t exp_g, input goal_t got);
    if (got.angle !== exp_g.angle)
      $display("%0t %s_angle exp %0d got %0d", $time, side, exp_g.angle, got.angle);
    if (got.angle_fixed !== exp_g.angle_fixed)
      $display("%0t %s_angle_fixed exp %0d got %0d", $time, side, exp_g.angle_fixed,
        got.angle_fixed);
    if (got.span !== exp_g.span)
      $display("%0t %s_dist exp %0d got %0d", $time, side, exp_g.span, got.span);
    if (got.seen !== exp_g.seen)
      $display("%0t %s_seen exp %0d got %0d", $time, side, exp_g.seen, got.seen);
    if (got.x_fixed !== exp_g.x_fixed)
      $display("%0t %s_x_fixed exp %0d got %0d", $time, side, exp_g.x_fixed, got.x_fixed);
    if (got.y_fixed !== exp_g.y_fixed)
      $display("%0t %s_y_fixed exp %0d got %0d", $time, side, exp_g.y_fixed, got.y_fixed);
  endfunction

  assign pending = expected_polar.size();

  always @(posedge clk) begin
    polar_t got;
    polar_t exp_p;
    if (!rst_n) begin
      start_mark <= 8'd0;
      end_mark <= 8'd255;
      unknown_mark <= 8'd128;
      off_x <= '0;
      off_y <= '0;
      yellow_attacks <= 1'b0;
      w_x <= '0;
      w_y <= '0;
      framing = 1'b0;
      coord_count = 0;
      for (int i = 0; i < 4; i++) coords[i] = '0;
      for (int i = 0; i < 8; i++) smooth[i] = 0;
      expected_polar.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (gftp_pkg::cfg_idx_t'(cfg_mon.index))
          gftp_pkg::CFG_START_MARKER: start_mark <= cfg_mon.data[7:0];
          gftp_pkg::CFG_END_MARKER: end_mark <= cfg_mon.data[7:0];
          gftp_pkg::CFG_UNKNOWN_MARKER: unknown_mark <= cfg_mon.data[7:0];
          gftp_pkg::CFG_OFFSET_X: off_x <= cfg_mon.data[14:0];
          gftp_pkg::CFG_OFFSET_Y: off_y <= cfg_mon.data[14:0];
          gftp_pkg::CFG_ATTACK_IS_YELLOW: yellow_attacks <= cfg_mon.data[0];
          gftp_pkg::CFG_WEIGHT_X: w_x <= cfg_mon.data;
          gftp_pkg::CFG_WEIGHT_Y: w_y <= cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.rx_byte, in_mon.imu_heading);
      if (out_mon.valid && out_mon.ready) begin
        got.atk = '{out_mon.atk_angle, out_mon.atk_angle_fixed, out_mon.atk_dist,
          out_mon.atk_seen, out_mon.atk_x_fixed, out_mon.atk_y_fixed};
        got.def = '{out_mon.def_angle, out_mon.def_angle_fixed, out_mon.def_dist,
          out_mon.def_seen, out_mon.def_x_fixed, out_mon.def_y_fixed};
        result_count <= result_count + 1;
        if (expected_polar.size() == 0) begin
          $display("%0t unexpected result transfer, exp none got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_p = expected_polar.pop_front();
          if (got !== exp_p) begin
            check_goal("atk", exp_p.atk, got.atk);
            check_goal("def", exp_p.def, got.def);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/goal_frame_to_polar_tracker_top_tb.sv =====
`timescale 1ns / 1ps
module goal_frame_to_polar_tracker_top_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 250;

  logic clk;
  logic rst_n;
  int fail_count;
  int pending;
  int result_count;
  int cycles = 0;
  int bytes_sent;
  int frames_sent;
  logic [7:0] st_mark, en_mark, unk_mark;
  bit no_idle;
  bit hold_out;

  gftp_in_if in_ch ();
  gftp_out_if out_ch ();
  gftp_cfg_if cfg_ch ();

  goal_frame_to_polar_tracker_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  goal_frame_to_polar_tracker_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input gftp_pkg::cfg_idx_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      gftp_pkg::CFG_START_MARKER: st_mark = value[7:0];
      gftp_pkg::CFG_END_MARKER: en_mark = value[7:0];
      gftp_pkg::CFG_UNKNOWN_MARKER: unk_mark = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic [8:0] imu);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.imu_heading <= imu;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] c0, c1, c2, c3, input logic [8:0] imu);
    send_byte(st_mark, 9'($urandom_range(0, 511)));
    send_byte(c0, 9'($urandom_range(0, 511)));
    send_byte(c1, 9'($urandom_range(0, 511)));
    send_byte(c2, 9'($urandom_range(0, 511)));
    send_byte(c3, 9'($urandom_range(0, 511)));
    send_byte(en_mark, imu);
    frames_sent++;
  endtask

  function automatic logic [7:0] pick_coord();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 70) c = 8'($urandom_range(0, 100));
    else if (r < 80) c = unk_mark;
    else c = 8'($urandom_range(0, 255));
    if (c == st_mark || c == en_mark) c = c ^ 8'h01;
    if (c == st_mark || c == en_mark) c = c ^ 8'h02;
    return c;
  endfunction

  function automatic logic [8:0] pick_heading();
    if ($urandom_range(0, 9) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, 359));
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_traffic(input int n_items);
    int target;
    int r;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_heading());
      end else if (r < 85) begin
        send_byte(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      end else if (r < 92) begin
        send_byte(st_mark, 9'd0);
        repeat ($urandom_range(0, 7)) send_byte(pick_coord(), 9'd0);
        send_byte(en_mark, pick_heading());
      end else begin
        send_byte(st_mark, 9'd0);
        repeat (4) send_byte(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
        send_byte(en_mark, pick_heading());
      end
    end
  endtask

  initial begin
    bytes_sent = 0;
    frames_sent = 0;
    no_idle = 1'b0;
    hold_out = 1'b0;
    st_mark = 8'd0;
    en_mark = 8'd255;
    unk_mark = 8'd128;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.imu_heading = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = gftp_pkg::CFG_START_MARKER;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults from reset
    send_frame(8'd50, 8'd50, 8'd50, 8'd50, 9'd0);
    send_frame(8'd0, 8'd100, 8'd100, 8'd0, 9'd90);
    send_frame(8'd128, 8'd20, 8'd254, 8'd1, 9'd180);
    send_frame(8'd100, 8'd100, 8'd0, 8'd0, 9'd181);
    send_frame(8'd1, 8'd254, 8'd77, 8'd128, 9'd359);
    send_frame(8'd30, 8'd70, 8'd60, 8'd40, 9'd360);
    send_frame(8'd10, 8'd90, 8'd90, 8'd10, 9'd511);
    send_byte(8'd12, 9'd0);
    send_byte(8'd255, 9'd45);
    send_byte(8'd0, 9'd0);
    repeat (3) send_byte(8'd33, 9'd0);
    send_byte(8'd255, 9'd10);
    send_byte(8'd0, 9'd0);
    repeat (9) send_byte(8'd66, 9'd0);
    send_byte(8'd255, 9'd10);
    drain();

    write_reg(gftp_pkg::CFG_START_MARKER, 16'h00AA);
    write_reg(gftp_pkg::CFG_END_MARKER, 16'h0055);
    write_reg(gftp_pkg::CFG_UNKNOWN_MARKER, 16'h007F);
    write_reg(gftp_pkg::CFG_OFFSET_X, 16'(12800));
    write_reg(gftp_pkg::CFG_OFFSET_Y, 16'(-12800));
    write_reg(gftp_pkg::CFG_ATTACK_IS_YELLOW, 16'd1);
    write_reg(gftp_pkg::CFG_WEIGHT_X, 16'hFFFF);
    write_reg(gftp_pkg::CFG_WEIGHT_Y, 16'h0000);
    send_frame(8'd0, 8'd255, 8'h7F, 8'd100, 9'd270);
    random_traffic(150);
    drain();

    write_reg(gftp_pkg::CFG_OFFSET_X, 16'(-12800));
    write_reg(gftp_pkg::CFG_OFFSET_Y, 16'(12800));
    write_reg(gftp_pkg::CFG_WEIGHT_X, 16'd0);
    write_reg(gftp_pkg::CFG_WEIGHT_Y, 16'hFFFF);
    write_reg(gftp_pkg::CFG_ATTACK_IS_YELLOW, 16'd0);
    write_reg(gftp_pkg::CFG_END_MARKER, 16'h00FE);
    no_idle = 1'b1;
    random_traffic(60);
    no_idle = 1'b0;
    hold_out = 1'b1;
    random_traffic(100);
    drain();

    // equal markers: start test wins, so no frame ever closes
    write_reg(gftp_pkg::CFG_START_MARKER, 16'h0033);
    write_reg(gftp_pkg::CFG_END_MARKER, 16'h0033);
    repeat (8) send_byte(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    drain();

    write_reg(gftp_pkg::CFG_START_MARKER, 16'h00FF);
    write_reg(gftp_pkg::CFG_END_MARKER, 16'h0000);
    write_reg(gftp_pkg::CFG_UNKNOWN_MARKER, 16'h00FF);
    write_reg(gftp_pkg::CFG_WEIGHT_X, 16'($urandom_range(0, 65535)));
    write_reg(gftp_pkg::CFG_WEIGHT_Y, 16'($urandom_range(0, 65535)));
    write_reg(gftp_pkg::CFG_OFFSET_X, 16'($signed($urandom_range(0, 25600)) - 12800));
    write_reg(gftp_pkg::CFG_OFFSET_Y, 16'($signed($urandom_range(0, 25600)) - 12800));
    write_reg(gftp_pkg::CFG_ATTACK_IS_YELLOW, 16'd1);
    random_traffic(220);
    drain();

    $display("bytes sent %0d, well-formed frames %0d, results checked %0d",
      bytes_sent, frames_sent, result_count);
    $display("covered marker, offset, weight and routing settings incl. extremes");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gftp_pkg.sv
sv/gftp_in_if.sv
sv/gftp_out_if.sv
sv/gftp_cfg_if.sv
sv/gftp_ctrl.sv
sv/gftp_dp.sv
sv/goal_frame_to_polar_tracker_top.sv
tb/goal_frame_to_polar_tracker_checker.sv
tb/goal_frame_to_polar_tracker_top_tb.sv
